// File: src/sbg_pkg.sv
// sbg_pkg: shared constants, types and controller/datapath command structs
// for the scan breakpoint grouper. No dependencies.
`timescale 1ns / 1ps

package sbg_pkg;

    localparam int MAX_POINTS = 4096;

    localparam int IDX_W   = 12;
    localparam int CNT_W   = 13;
    localparam int COORD_W = 18;
    localparam int RANGE_W = 18;
    localparam int DIST_W  = 19;

    localparam logic [IDX_W-1:0] IDX_CAP   =
        IDX_W'((MAX_POINTS - 1 > 4095) ? 4095 : MAX_POINTS - 1);
    localparam logic [CNT_W-1:0] COUNT_CAP =
        CNT_W'((MAX_POINTS > 8191) ? 8191 : MAX_POINTS);

    // multiplier: A operand, B operand in 16-bit digits, product/accumulator
    localparam int MUL_AW = 52;
    localparam int MUL_BW = 64;
    localparam int MUL_PW = 104;
    localparam int DIG_W  = 16;

    typedef logic [MUL_AW-1:0] mul_a_t;
    typedef logic [MUL_BW-1:0] mul_b_t;
    typedef logic [MUL_PW-1:0] mul_p_t;
    typedef logic [2:0]        mul_dig_t;

    // square root: 40-bit radicand, 20-bit root, one bit per step
    localparam int SQ_IW    = 40;
    localparam int SQ_RW    = 20;
    localparam int SQ_STEPS = 20;

    typedef logic [SQ_IW-1:0] sq_in_t;
    typedef logic [SQ_RW-1:0] sq_root_t;

    // register map
    localparam logic [1:0] REG_MAX_DIST = 2'd0;
    localparam logic [1:0] REG_PROP     = 2'd1;
    localparam logic [1:0] REG_SINE     = 2'd2;
    localparam logic [1:0] REG_MIN_PTS  = 2'd3;

    localparam logic [15:0] MAX_DIST_RST = 16'd100;
    localparam logic [15:0] PROP_RST     = 16'd412;
    localparam logic [15:0] SINE_RST     = 16'd823;
    localparam logic [12:0] MIN_PTS_RST  = 13'd5;

    typedef enum logic [4:0] {
        OP_NONE,
        OP_LOAD,
        OP_MUL_XX,
        OP_MUL_YY,
        OP_SQRT_R,
        OP_MUL_DX,
        OP_MUL_DY,
        OP_SQRT_D,
        OP_MUL_RP,
        OP_MUL_F12,
        OP_MUL_F34,
        OP_MUL_H,
        OP_MUL_RB,
        OP_MUL_Q,
        OP_MUL_QQ,
        OP_FIRST,
        OP_JOIN,
        OP_BREAK,
        OP_ADVANCE,
        OP_LAST
    } sbg_op_t;

    typedef struct packed {
        sbg_op_t op;
        logic    go;
    } sbg_cmd_t;

    typedef struct packed {
        logic unit_done;
        logic have_prev;
        logic last;
        logic join_ok;
    } sbg_status_t;

endpackage

// File: src/sbg_point_if.sv
// sbg_point_if: input point channel (valid/ready plus point payload).
// Depends on nothing.
`timescale 1ns / 1ps

interface sbg_point_if;
    logic        valid;
    logic        ready;
    logic [17:0] x_mm;
    logic [17:0] y_mm;
    logic        last_of_scan;

    modport source (output valid, output x_mm, output y_mm, output last_of_scan,
                    input ready);
    modport sink   (input valid, input x_mm, input y_mm, input last_of_scan,
                    output ready);
endinterface

// File: src/sbg_group_if.sv
// sbg_group_if: output group channel (valid/ready plus group payload).
// Depends on nothing.
`timescale 1ns / 1ps

interface sbg_group_if;
    logic        valid;
    logic        ready;
    logic [11:0] group_start;
    logic [12:0] group_count;
    logic        group_visible;
    logic        group_kept;
    logic        scan_done;

    modport source (output valid, output group_start, output group_count,
                    output group_visible, output group_kept, output scan_done,
                    input ready);
    modport sink   (input valid, input group_start, input group_count,
                    input group_visible, input group_kept, input scan_done,
                    output ready);
endinterface

// File: src/sbg_mul.sv
// sbg_mul: sequential multiply-accumulate, one 16-bit digit of B per cycle.
// Depends on sbg_pkg.
`timescale 1ns / 1ps

module sbg_mul
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              start,
    input  logic              accum,
    input  sbg_pkg::mul_a_t   a,
    input  sbg_pkg::mul_b_t   b,
    input  sbg_pkg::mul_dig_t digits,
    output sbg_pkg::mul_p_t   acc,
    output logic              done
);

    sbg_pkg::mul_a_t   a_reg;
    sbg_pkg::mul_b_t   b_reg;
    sbg_pkg::mul_p_t   acc_reg;
    sbg_pkg::mul_dig_t cnt_reg;
    logic [1:0]        sh_reg;
    logic              done_reg;

    logic [sbg_pkg::MUL_AW+sbg_pkg::DIG_W-1:0] pp;
    sbg_pkg::mul_p_t                           pp_ext;
    sbg_pkg::mul_p_t                           pp_sh;

    assign pp     = a_reg * b_reg[sbg_pkg::DIG_W-1:0];
    assign pp_ext = sbg_pkg::mul_p_t'(pp);

    always_comb
    begin
        case (sh_reg)
            2'd0:    pp_sh = pp_ext;
            2'd1:    pp_sh = pp_ext << sbg_pkg::DIG_W;
            2'd2:    pp_sh = pp_ext << (2 * sbg_pkg::DIG_W);
            default: pp_sh = pp_ext << (3 * sbg_pkg::DIG_W);
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cnt_reg  <= '0;
            done_reg <= 1'b0;
        end
        else if (start)
        begin
            cnt_reg  <= digits;
            done_reg <= 1'b0;
        end
        else if (cnt_reg != '0)
        begin
            cnt_reg  <= cnt_reg - 3'd1;
            done_reg <= (cnt_reg == 3'd1);
        end
        else
        begin
            done_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (start)
        begin
            a_reg  <= a;
            b_reg  <= b;
            sh_reg <= 2'd0;
            if (!accum)
            begin
                acc_reg <= '0;
            end
        end
        else if (cnt_reg != '0)
        begin
            acc_reg <= acc_reg + pp_sh;
            b_reg   <= b_reg >> sbg_pkg::DIG_W;
            sh_reg  <= sh_reg + 2'd1;
        end
    end

    assign acc  = acc_reg;
    assign done = done_reg;

endmodule

// File: src/sbg_sqrt.sv
// sbg_sqrt: integer floor square root, one root bit per cycle.
// Depends on sbg_pkg.
`timescale 1ns / 1ps

module sbg_sqrt
(
    input  logic             clk,
    input  logic             rst_n,
    input  logic             start,
    input  sbg_pkg::sq_in_t  radicand,
    output sbg_pkg::sq_root_t root,
    output logic             done
);

    sbg_pkg::sq_in_t   n_reg;
    logic [21:0]       rem_reg;
    sbg_pkg::sq_root_t root_reg;
    logic [4:0]        cnt_reg;
    logic              done_reg;

    logic [23:0] rem_in;
    logic [23:0] trial;
    logic [23:0] diff;
    logic        fits;

    assign rem_in = {rem_reg, n_reg[sbg_pkg::SQ_IW-1 -: 2]};
    assign trial  = {2'b00, root_reg, 2'b01};
    assign diff   = rem_in - trial;
    assign fits   = (rem_in >= trial);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cnt_reg  <= '0;
            done_reg <= 1'b0;
        end
        else if (start)
        begin
            cnt_reg  <= 5'(sbg_pkg::SQ_STEPS);
            done_reg <= 1'b0;
        end
        else if (cnt_reg != '0)
        begin
            cnt_reg  <= cnt_reg - 5'd1;
            done_reg <= (cnt_reg == 5'd1);
        end
        else
        begin
            done_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (start)
        begin
            n_reg    <= radicand;
            rem_reg  <= '0;
            root_reg <= '0;
        end
        else if (cnt_reg != '0)
        begin
            n_reg    <= n_reg << 2;
            rem_reg  <= fits ? diff[21:0] : rem_in[21:0];
            root_reg <= {root_reg[sbg_pkg::SQ_RW-2:0], fits};
        end
    end

    assign root = root_reg;
    assign done = done_reg;

endmodule

// File: src/sbg_dpath.sv
// sbg_dpath: point, group and arithmetic registers; shared multiplier and
// square root unit driven by controller commands. Depends on sbg_pkg,
// sbg_mul, sbg_sqrt.
`timescale 1ns / 1ps

module sbg_dpath
(
    input  logic                clk,
    input  logic                rst_n,
    input  sbg_pkg::sbg_cmd_t   cmd,
    output sbg_pkg::sbg_status_t status,
    input  logic [15:0]         max_dist,
    input  logic [15:0]         prop,
    input  logic [15:0]         sine,
    input  logic [12:0]         min_pts,
    input  logic [17:0]         x_mm,
    input  logic [17:0]         y_mm,
    input  logic                last_of_scan,
    output logic [11:0]         group_start,
    output logic [12:0]         group_count,
    output logic                group_visible,
    output logic                group_kept,
    output logic                scan_done
);

    logic [17:0] x_reg, y_reg;
    logic        last_reg;
    logic [17:0] prev_x_reg, prev_y_reg;
    logic [17:0] prev_range_reg;
    logic [17:0] r_reg;
    logic [18:0] d_reg;
    logic [41:0] p12_reg;
    logic [83:0] h_reg;
    logic        join_reg, small_reg, large_reg;

    logic [11:0] open_start_reg;
    logic [12:0] open_count_reg;
    logic        open_vis_reg;
    logic [11:0] index_reg;
    logic        have_prev_reg;

    logic [11:0] o_start_reg;
    logic [12:0] o_count_reg;
    logic        o_vis_reg, o_kept_reg, o_done_reg;

    logic [17:0] ax, ay, ux, uy;
    logic [18:0] dx, dy, ndx, ndy;
    logic signed [21:0] ha, hb, hc, s2, s3, s4;
    logic [20:0] f1, f2, f3, f4;
    logic        neg;
    logic [35:0] thr, lhs;
    logic [113:0] h_sh, q_ext;
    logic        r_less, zero_rng, closed_vis, kept;

    logic              mul_start, mul_accum, mul_done;
    sbg_pkg::mul_a_t   mul_a;
    sbg_pkg::mul_b_t   mul_b;
    sbg_pkg::mul_dig_t mul_dig;
    sbg_pkg::mul_p_t   acc;
    logic              sq_start, sq_done;
    sbg_pkg::sq_root_t root;

    function automatic logic [20:0] mag21(input logic signed [21:0] v);
        logic [21:0] nv;
        nv = 22'(-v);
        return v[21] ? nv[20:0] : v[20:0];
    endfunction

    assign ax  = x_reg[17] ? 18'(~x_reg + 18'd1) : x_reg;
    assign ay  = y_reg[17] ? 18'(~y_reg + 18'd1) : y_reg;
    assign dx  = {x_reg[17], x_reg} - {prev_x_reg[17], prev_x_reg};
    assign dy  = {y_reg[17], y_reg} - {prev_y_reg[17], prev_y_reg};
    assign ndx = ~dx + 19'd1;
    assign ndy = ~dy + 19'd1;
    assign ux  = dx[18] ? ndx[17:0] : dx[17:0];
    assign uy  = dy[18] ? ndy[17:0] : dy[17:0];

    assign ha  = signed'({4'b0, r_reg});
    assign hb  = signed'({4'b0, prev_range_reg});
    assign hc  = signed'({3'b0, d_reg});
    assign s2  = hb + hc - ha;
    assign s3  = ha + hc - hb;
    assign s4  = ha + hb - hc;
    assign f1  = 21'(r_reg) + 21'(prev_range_reg) + 21'(d_reg);
    assign f2  = mag21(s2);
    assign f3  = mag21(s3);
    assign f4  = mag21(s4);
    assign neg = s2[21] ^ s3[21] ^ s4[21];

    assign lhs = {1'b0, d_reg, 16'b0};
    assign thr = {4'b0, max_dist, 16'b0} + 36'(acc);

    assign h_sh  = {h_reg, 30'b0};
    assign q_ext = 114'(acc);

    assign r_less     = (r_reg < prev_range_reg);
    assign zero_rng   = (r_reg == '0) || (prev_range_reg == '0);
    assign closed_vis = open_vis_reg & ~(small_reg & r_less);
    assign kept       = (open_count_reg >= min_pts);

    always_comb
    begin
        mul_a     = '0;
        mul_b     = '0;
        mul_dig   = 3'd2;
        mul_accum = 1'b0;
        mul_start = 1'b0;
        sq_start  = 1'b0;
        case (cmd.op)
            sbg_pkg::OP_MUL_XX:
            begin
                mul_a = sbg_pkg::mul_a_t'(ax);
                mul_b = sbg_pkg::mul_b_t'(ax);
                mul_start = cmd.go;
            end
            sbg_pkg::OP_MUL_YY:
            begin
                mul_a = sbg_pkg::mul_a_t'(ay);
                mul_b = sbg_pkg::mul_b_t'(ay);
                mul_accum = 1'b1;
                mul_start = cmd.go;
            end
            sbg_pkg::OP_MUL_DX:
            begin
                mul_a = sbg_pkg::mul_a_t'(ux);
                mul_b = sbg_pkg::mul_b_t'(ux);
                mul_start = cmd.go;
            end
            sbg_pkg::OP_MUL_DY:
            begin
                mul_a = sbg_pkg::mul_a_t'(uy);
                mul_b = sbg_pkg::mul_b_t'(uy);
                mul_accum = 1'b1;
                mul_start = cmd.go;
            end
            sbg_pkg::OP_MUL_RP:
            begin
                mul_a = sbg_pkg::mul_a_t'(r_reg);
                mul_b = sbg_pkg::mul_b_t'(prop);
                mul_dig = 3'd1;
                mul_start = cmd.go;
            end
            sbg_pkg::OP_MUL_F12:
            begin
                mul_a = sbg_pkg::mul_a_t'(f1);
                mul_b = sbg_pkg::mul_b_t'(f2);
                mul_start = cmd.go;
            end
            sbg_pkg::OP_MUL_F34:
            begin
                mul_a = sbg_pkg::mul_a_t'(f3);
                mul_b = sbg_pkg::mul_b_t'(f4);
                mul_start = cmd.go;
            end
            sbg_pkg::OP_MUL_H:
            begin
                mul_a = sbg_pkg::mul_a_t'(p12_reg);
                mul_b = sbg_pkg::mul_b_t'(acc[41:0]);
                mul_dig = 3'd3;
                mul_start = cmd.go;
            end
            sbg_pkg::OP_MUL_RB:
            begin
                mul_a = sbg_pkg::mul_a_t'(r_reg);
                mul_b = sbg_pkg::mul_b_t'(prev_range_reg);
                mul_start = cmd.go;
            end
            sbg_pkg::OP_MUL_Q:
            begin
                mul_a = sbg_pkg::mul_a_t'(acc[35:0]);
                mul_b = sbg_pkg::mul_b_t'(sine);
                mul_dig = 3'd1;
                mul_start = cmd.go;
            end
            sbg_pkg::OP_MUL_QQ:
            begin
                mul_a = sbg_pkg::mul_a_t'(acc[51:0]);
                mul_b = sbg_pkg::mul_b_t'(acc[51:0]);
                mul_dig = 3'd4;
                mul_start = cmd.go;
            end
            sbg_pkg::OP_SQRT_R, sbg_pkg::OP_SQRT_D:
            begin
                sq_start = cmd.go;
            end
            default:
            begin
                mul_start = 1'b0;
            end
        endcase
    end

    sbg_mul u_mul
    (
        .clk    (clk),
        .rst_n  (rst_n),
        .start  (mul_start),
        .accum  (mul_accum),
        .a      (mul_a),
        .b      (mul_b),
        .digits (mul_dig),
        .acc    (acc),
        .done   (mul_done)
    );

    sbg_sqrt u_sqrt
    (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (sq_start),
        .radicand (sbg_pkg::sq_in_t'(acc)),
        .root     (root),
        .done     (sq_done)
    );

    // point capture on load, and arithmetic results stored as each unit finishes
    always_ff @(posedge clk)
    begin
        if (cmd.go && cmd.op == sbg_pkg::OP_LOAD)
        begin
            x_reg    <= x_mm;
            y_reg    <= y_mm;
            last_reg <= last_of_scan;
        end
        if (sq_done && cmd.op == sbg_pkg::OP_SQRT_R)
        begin
            r_reg <= root[17:0];
        end
        if (sq_done && cmd.op == sbg_pkg::OP_SQRT_D)
        begin
            d_reg <= root[18:0];
        end
        if (mul_done)
        begin
            case (cmd.op)
                sbg_pkg::OP_MUL_RP:  join_reg <= (lhs < thr);
                sbg_pkg::OP_MUL_F12: p12_reg  <= acc[41:0];
                sbg_pkg::OP_MUL_H:   h_reg    <= neg ? '0 : acc[83:0];
                sbg_pkg::OP_MUL_QQ:
                begin
                    small_reg <= ~zero_rng & (h_sh < q_ext);
                    large_reg <= zero_rng | (h_sh > q_ext);
                end
                default: join_reg <= join_reg;
            endcase
        end
    end

    // output payload
    always_ff @(posedge clk)
    begin
        if (cmd.go && (cmd.op == sbg_pkg::OP_BREAK || cmd.op == sbg_pkg::OP_LAST))
        begin
            o_start_reg <= open_start_reg;
            o_count_reg <= open_count_reg;
            o_kept_reg  <= kept;
            o_vis_reg   <= (cmd.op == sbg_pkg::OP_BREAK) ? closed_vis : open_vis_reg;
            o_done_reg  <= (cmd.op == sbg_pkg::OP_LAST);
        end
    end

    // scan and open group state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            prev_x_reg     <= '0;
            prev_y_reg     <= '0;
            prev_range_reg <= '0;
            open_start_reg <= '0;
            open_count_reg <= '0;
            open_vis_reg   <= 1'b1;
            index_reg      <= '0;
            have_prev_reg  <= 1'b0;
        end
        else if (cmd.go)
        begin
            case (cmd.op)
                sbg_pkg::OP_FIRST:
                begin
                    open_start_reg <= index_reg;
                    open_count_reg <= 13'd1;
                    open_vis_reg   <= 1'b1;
                    have_prev_reg  <= 1'b1;
                end
                sbg_pkg::OP_JOIN:
                begin
                    if (open_count_reg < sbg_pkg::COUNT_CAP)
                    begin
                        open_count_reg <= open_count_reg + 13'd1;
                    end
                end
                sbg_pkg::OP_BREAK:
                begin
                    open_start_reg <= index_reg;
                    open_count_reg <= 13'd1;
                    open_vis_reg   <= large_reg | r_less;
                end
                sbg_pkg::OP_ADVANCE:
                begin
                    prev_x_reg     <= x_reg;
                    prev_y_reg     <= y_reg;
                    prev_range_reg <= r_reg;
                    if (index_reg < sbg_pkg::IDX_CAP)
                    begin
                        index_reg <= index_reg + 12'd1;
                    end
                end
                sbg_pkg::OP_LAST:
                begin
                    prev_x_reg     <= '0;
                    prev_y_reg     <= '0;
                    prev_range_reg <= '0;
                    open_start_reg <= '0;
                    open_count_reg <= '0;
                    open_vis_reg   <= 1'b1;
                    index_reg      <= '0;
                    have_prev_reg  <= 1'b0;
                end
                default:
                begin
                    have_prev_reg <= have_prev_reg;
                end
            endcase
        end
    end

    assign status.unit_done = mul_done | sq_done;
    assign status.have_prev = have_prev_reg;
    assign status.last      = last_reg;
    assign status.join_ok   = join_reg;

    assign group_start   = o_start_reg;
    assign group_count   = o_count_reg;
    assign group_visible = o_vis_reg;
    assign group_kept    = o_kept_reg;
    assign scan_done     = o_done_reg;

endmodule

// File: src/sbg_ctrl.sv
// sbg_ctrl: sequencing state machine; issues datapath commands and owns the
// input ready and output valid handshakes. Depends on sbg_pkg.
`timescale 1ns / 1ps

module sbg_ctrl
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 in_valid,
    output logic                 in_ready,
    output logic                 out_valid,
    input  logic                 out_ready,
    output sbg_pkg::sbg_cmd_t    cmd,
    input  sbg_pkg::sbg_status_t status
);

    typedef enum logic [4:0] {
        ST_IDLE,
        ST_MXX,
        ST_MYY,
        ST_SQR,
        ST_FIRST,
        ST_MDX,
        ST_MDY,
        ST_SQD,
        ST_MRP,
        ST_JUDGE,
        ST_MF12,
        ST_MF34,
        ST_MH,
        ST_MRB,
        ST_MQ,
        ST_MQQ,
        ST_BRK,
        ST_ADV,
        ST_LAST
    } state_t;

    state_t state_reg, state_next, unit_next;
    logic   issued_reg, issued_next;
    logic   out_valid_reg, out_valid_next;
    logic   is_unit, out_free;
    sbg_pkg::sbg_op_t unit_op;

    assign out_free = ~out_valid_reg | out_ready;

    always_comb
    begin
        state_next     = state_reg;
        issued_next    = issued_reg;
        out_valid_next = out_valid_reg & ~out_ready;
        cmd.op         = sbg_pkg::OP_NONE;
        cmd.go         = 1'b0;
        is_unit        = 1'b0;
        unit_op        = sbg_pkg::OP_NONE;
        unit_next      = ST_IDLE;
        case (state_reg)
            ST_IDLE:
            begin
                if (in_valid)
                begin
                    cmd.op     = sbg_pkg::OP_LOAD;
                    cmd.go     = 1'b1;
                    state_next = ST_MXX;
                end
            end
            ST_MXX:  begin is_unit = 1'b1; unit_op = sbg_pkg::OP_MUL_XX;  unit_next = ST_MYY; end
            ST_MYY:  begin is_unit = 1'b1; unit_op = sbg_pkg::OP_MUL_YY;  unit_next = ST_SQR; end
            ST_SQR:
            begin
                is_unit   = 1'b1;
                unit_op   = sbg_pkg::OP_SQRT_R;
                unit_next = status.have_prev ? ST_MDX : ST_FIRST;
            end
            ST_MDX:  begin is_unit = 1'b1; unit_op = sbg_pkg::OP_MUL_DX;  unit_next = ST_MDY; end
            ST_MDY:  begin is_unit = 1'b1; unit_op = sbg_pkg::OP_MUL_DY;  unit_next = ST_SQD; end
            ST_SQD:  begin is_unit = 1'b1; unit_op = sbg_pkg::OP_SQRT_D;  unit_next = ST_MRP; end
            ST_MRP:  begin is_unit = 1'b1; unit_op = sbg_pkg::OP_MUL_RP;  unit_next = ST_JUDGE; end
            ST_MF12: begin is_unit = 1'b1; unit_op = sbg_pkg::OP_MUL_F12; unit_next = ST_MF34; end
            ST_MF34: begin is_unit = 1'b1; unit_op = sbg_pkg::OP_MUL_F34; unit_next = ST_MH; end
            ST_MH:   begin is_unit = 1'b1; unit_op = sbg_pkg::OP_MUL_H;   unit_next = ST_MRB; end
            ST_MRB:  begin is_unit = 1'b1; unit_op = sbg_pkg::OP_MUL_RB;  unit_next = ST_MQ; end
            ST_MQ:   begin is_unit = 1'b1; unit_op = sbg_pkg::OP_MUL_Q;   unit_next = ST_MQQ; end
            ST_MQQ:  begin is_unit = 1'b1; unit_op = sbg_pkg::OP_MUL_QQ;  unit_next = ST_BRK; end
            ST_FIRST:
            begin
                cmd.op     = sbg_pkg::OP_FIRST;
                cmd.go     = 1'b1;
                state_next = ST_ADV;
            end
            ST_JUDGE:
            begin
                if (status.join_ok)
                begin
                    cmd.op     = sbg_pkg::OP_JOIN;
                    cmd.go     = 1'b1;
                    state_next = ST_ADV;
                end
                else
                begin
                    state_next = ST_MF12;
                end
            end
            ST_BRK:
            begin
                if (out_free)
                begin
                    cmd.op         = sbg_pkg::OP_BREAK;
                    cmd.go         = 1'b1;
                    out_valid_next = 1'b1;
                    state_next     = ST_ADV;
                end
            end
            ST_ADV:
            begin
                cmd.op     = sbg_pkg::OP_ADVANCE;
                cmd.go     = 1'b1;
                state_next = status.last ? ST_LAST : ST_IDLE;
            end
            ST_LAST:
            begin
                if (out_free)
                begin
                    cmd.op         = sbg_pkg::OP_LAST;
                    cmd.go         = 1'b1;
                    out_valid_next = 1'b1;
                    state_next     = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase

        if (is_unit)
        begin
            cmd.op = unit_op;
            cmd.go = ~issued_reg;
            if (!issued_reg)
            begin
                issued_next = 1'b1;
            end
            else if (status.unit_done)
            begin
                issued_next = 1'b0;
                state_next  = unit_next;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            issued_reg    <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            issued_reg    <= issued_next;
            out_valid_reg <= out_valid_next;
        end
    end

    assign in_ready  = (state_reg == ST_IDLE);
    assign out_valid = out_valid_reg;

endmodule

// File: src/scan_breakpoint_grouper.sv
// scan_breakpoint_grouper: top level with APB register file, controller and
// datapath. Depends on sbg_pkg, sbg_point_if, sbg_group_if, sbg_ctrl, sbg_dpath.
//
//   channel  dir  protocol         payload
//   point    in   valid/ready      x_mm, y_mm, last_of_scan
//   group    out  valid/ready      group_start, group_count, group_visible,
//                                  group_kept, scan_done
//   apb      in   psel/penable     4 registers at 0x0, 0x4, 0x8, 0xC
//
// One request at a time; the time per point is set by the shared
// 16-bit-digit multiplier and the one-bit-per-cycle square root unit (one
// root for a scan's first point, two for any other). A last point then
// closes the scan in ST_LAST. Reset (rst_n low, asynchronous) clears all scan
// state and loads register defaults. A stalled result holds in the output
// register; the next point is taken meanwhile, and a further result waits.
`timescale 1ns / 1ps

module scan_breakpoint_grouper
(
    input  logic        clk,
    input  logic        rst_n,
    sbg_point_if.sink   point,
    sbg_group_if.source group,
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [3:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready
);

    logic [15:0] max_dist_reg;
    logic [15:0] prop_reg;
    logic [15:0] sine_reg;
    logic [12:0] min_pts_reg;
    logic        wr_en;

    sbg_pkg::sbg_cmd_t    cmd;
    sbg_pkg::sbg_status_t status;

    assign pready = 1'b1;
    assign wr_en  = psel & penable & pwrite;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            max_dist_reg <= sbg_pkg::MAX_DIST_RST;
            prop_reg     <= sbg_pkg::PROP_RST;
            sine_reg     <= sbg_pkg::SINE_RST;
            min_pts_reg  <= sbg_pkg::MIN_PTS_RST;
        end
        else if (wr_en)
        begin
            case (paddr[3:2])
                sbg_pkg::REG_MAX_DIST: max_dist_reg <= pwdata[15:0];
                sbg_pkg::REG_PROP:     prop_reg     <= pwdata[15:0];
                sbg_pkg::REG_SINE:     sine_reg     <= pwdata[15:0];
                sbg_pkg::REG_MIN_PTS:  min_pts_reg  <= pwdata[12:0];
                default:               min_pts_reg  <= min_pts_reg;
            endcase
        end
    end

    always_comb
    begin
        case (paddr[3:2])
            sbg_pkg::REG_MAX_DIST: prdata = {16'b0, max_dist_reg};
            sbg_pkg::REG_PROP:     prdata = {16'b0, prop_reg};
            sbg_pkg::REG_SINE:     prdata = {16'b0, sine_reg};
            sbg_pkg::REG_MIN_PTS:  prdata = {19'b0, min_pts_reg};
            default:               prdata = '0;
        endcase
    end

    sbg_ctrl u_ctrl
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (point.valid),
        .in_ready  (point.ready),
        .out_valid (group.valid),
        .out_ready (group.ready),
        .cmd       (cmd),
        .status    (status)
    );

    sbg_dpath u_dpath
    (
        .clk           (clk),
        .rst_n         (rst_n),
        .cmd           (cmd),
        .status        (status),
        .max_dist      (max_dist_reg),
        .prop          (prop_reg),
        .sine          (sine_reg),
        .min_pts       (min_pts_reg),
        .x_mm          (point.x_mm),
        .y_mm          (point.y_mm),
        .last_of_scan  (point.last_of_scan),
        .group_start   (group.group_start),
        .group_count   (group.group_count),
        .group_visible (group.group_visible),
        .group_kept    (group.group_kept),
        .scan_done     (group.scan_done)
    );

endmodule

// File: verif/scan_breakpoint_grouper_test.sv
// scan_breakpoint_grouper_test: self-checking bench for the scan breakpoint grouper.
// Drives lidar points with random stalls, predicts the closed groups, checks each against
// the prediction. Depends on sbg_pkg, sbg_point_if, sbg_group_if, scan_breakpoint_grouper.
`timescale 1ns / 1ps

module scan_breakpoint_grouper_test;

    localparam int STALL_PCT  = 15;
    localparam int IDLE_LIMIT = 50000;
    localparam int DRAIN_CYC  = 300;

    typedef struct {
        logic signed [17:0] x;
        logic signed [17:0] y;
        logic               last;
    } point_t;

    typedef struct {
        logic [11:0] start;
        logic [12:0] count;
        logic        visible;
        logic        kept;
        logic        done;
    } group_t;

    logic clk = 1'b0;
    logic rst_n = 1'b0;
    logic psel = 1'b0, penable = 1'b0, pwrite = 1'b0;
    logic [3:0]  paddr = '0;
    logic [31:0] pwdata = '0;
    logic [31:0] prdata;
    logic        pready;

    sbg_point_if point ();
    sbg_group_if group ();

    scan_breakpoint_grouper DUT (
        .clk(clk), .rst_n(rst_n), .point(point.sink), .group(group.source),
        .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
        .pwdata(pwdata), .prdata(prdata), .pready(pready)
    );

    always #5 clk = ~clk;

    // configuration copy
    logic [15:0] cfg_max_dist = sbg_pkg::MAX_DIST_RST;
    logic [15:0] cfg_prop     = sbg_pkg::PROP_RST;
    logic [15:0] cfg_sine     = sbg_pkg::SINE_RST;
    logic [12:0] cfg_min_pts  = sbg_pkg::MIN_PTS_RST;

    // scan state copy
    longint      sc_prev_x, sc_prev_y;
    longint unsigned sc_prev_range;
    logic [11:0] sc_start;
    logic [12:0] sc_count;
    logic        sc_visible;
    logic [11:0] sc_index;
    logic        sc_have_prev;

    point_t pending[$];
    group_t expected_groups[$];
    logic   pt_took = 1'b0;
    logic   quiet = 1'b0;
    int     errors = 0, n_points = 0, n_groups = 0, n_breaks = 0, idle_cycles = 0;

    function automatic longint unsigned int_sqrt(longint unsigned n);
        longint unsigned res, bits;
        res = 0;
        bits = 64'd1 << 62;
        while (bits > n) bits >>= 2;
        while (bits != 0)
        begin
            if (n >= res + bits)
            begin
                n -= res + bits;
                res = (res >> 1) + bits;
            end
            else
                res >>= 1;
            bits >>= 2;
        end
        return res;
    endfunction

    function automatic longint unsigned abs64(longint v);
        return (v < 0) ? longint'(-v) : v;
    endfunction

    function automatic group_t close_group(logic done);
        group_t g;
        g.start   = sc_start;
        g.count   = sc_count;
        g.visible = sc_visible;
        g.kept    = (sc_count >= cfg_min_pts);
        g.done    = done;
        return g;
    endfunction

    task automatic clear_scan();
        sc_prev_x = 0; sc_prev_y = 0; sc_prev_range = 0;
        sc_start = '0; sc_count = '0; sc_visible = 1'b1;
        sc_index = '0; sc_have_prev = 1'b0;
    endtask

    task automatic predict_groups(point_t p);
        longint x, y, a, b, c;
        longint unsigned r, d, thr, f1, f2, f3, f4, q;
        logic [127:0] heron, qq;
        logic neg, sine_small, sine_large;
        x = p.x;
        y = p.y;
        r = int_sqrt(abs64(x) * abs64(x) + abs64(y) * abs64(y));
        if (!sc_have_prev)
        begin
            sc_start = sc_index;
            sc_count = 13'd1;
            sc_visible = 1'b1;
            sc_have_prev = 1'b1;
        end
        else
        begin
            d = int_sqrt(abs64(x - sc_prev_x) * abs64(x - sc_prev_x)
                       + abs64(y - sc_prev_y) * abs64(y - sc_prev_y));
            thr = 64'(cfg_max_dist) * 65536 + r * 64'(cfg_prop);
            if (d * 65536 < thr)
            begin
                if (sc_count < sbg_pkg::COUNT_CAP) sc_count++;
            end
            else
            begin
                n_breaks++;
                a = r; b = sc_prev_range; c = d;
                neg = (a + b + c < 0) ^ (-a + b + c < 0) ^ (a - b + c < 0) ^ (a + b - c < 0);
                f1 = abs64(a + b + c); f2 = abs64(-a + b + c);
                f3 = abs64(a - b + c); f4 = abs64(a + b - c);
                heron = neg ? 128'd0 : (128'(f1 * f2) * 128'(f3 * f4)) << 30;
                if (r == 0 || sc_prev_range == 0)
                begin
                    sine_small = 1'b0;
                    sine_large = 1'b1;
                end
                else
                begin
                    q = r * sc_prev_range * 64'(cfg_sine);
                    qq = 128'(q) * 128'(q);
                    sine_small = heron < qq;
                    sine_large = heron > qq;
                end
                if (sine_small && r < sc_prev_range) sc_visible = 1'b0;
                expected_groups = {expected_groups, close_group(1'b0)};
                sc_start = sc_index;
                sc_count = 13'd1;
                sc_visible = sine_large || r < sc_prev_range;
            end
        end
        sc_prev_x = x;
        sc_prev_y = y;
        sc_prev_range = r & 64'h3FFFF;
        if (sc_index < sbg_pkg::IDX_CAP) sc_index++;
        if (p.last)
        begin
            expected_groups = {expected_groups, close_group(1'b1)};
            clear_scan();
        end
    endtask

    task automatic report_mismatch(string what, int got, int want);
        $display("mismatch on group %0d: %s got %0d expected %0d", n_groups, what, got, want);
        errors++;
    endtask

    // point driver and output ready
    always @(negedge clk)
    begin
        if (rst_n && (!point.valid || pt_took))
        begin
            if (pending.size() > 0 && (quiet || $urandom_range(0, 99) >= STALL_PCT))
            begin
                point.valid        <= 1'b1;
                point.x_mm         <= pending[0].x;
                point.y_mm         <= pending[0].y;
                point.last_of_scan <= pending[0].last;
                void'(pending.pop_front());
            end
            else
                point.valid <= 1'b0;
        end
        if (rst_n)
            group.ready <= quiet || ($urandom_range(0, 99) >= STALL_PCT);
    end

    // monitor and prediction
    always @(posedge clk)
    begin
        group_t want;
        pt_took <= point.valid && point.ready;
        if (group.valid && group.ready)
        begin
            if (expected_groups.size() == 0)
            begin
                $display("group with no request pending: start %0d count %0d",
                         group.group_start, group.group_count);
                errors++;
            end
            else
            begin
                want = expected_groups.pop_front();
                if (group.group_start !== want.start)
                    report_mismatch("start", group.group_start, want.start);
                if (group.group_count !== want.count)
                    report_mismatch("count", group.group_count, want.count);
                if (group.group_visible !== want.visible)
                    report_mismatch("visible", group.group_visible, want.visible);
                if (group.group_kept !== want.kept)
                    report_mismatch("kept", group.group_kept, want.kept);
                if (group.scan_done !== want.done)
                    report_mismatch("scan_done", group.scan_done, want.done);
            end
            n_groups++;
        end
        if (point.valid && point.ready)
        begin
            point_t p;
            p.x = point.x_mm;
            p.y = point.y_mm;
            p.last = point.last_of_scan;
            predict_groups(p);
            n_points++;
        end
    end

    // watchdog
    always @(posedge clk)
    begin
        if ((point.valid && point.ready) || (group.valid && group.ready) || psel)
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles >= IDLE_LIMIT)
        begin
            $display("timeout: no request moved for %0d cycles", IDLE_LIMIT);
            $display("== FAIL ==");
            $finish;
        end
    end

    task automatic reg_write(logic [1:0] idx, logic [31:0] value);
        @(negedge clk);
        psel = 1'b1; penable = 1'b0; pwrite = 1'b1; paddr = {idx, 2'b00}; pwdata = value;
        @(negedge clk);
        penable = 1'b1;
        @(negedge clk);
        psel = 1'b0; penable = 1'b0; pwrite = 1'b0;
        case (idx)
            sbg_pkg::REG_MAX_DIST: cfg_max_dist = value[15:0];
            sbg_pkg::REG_PROP:     cfg_prop     = value[15:0];
            sbg_pkg::REG_SINE:     cfg_sine     = value[15:0];
            default:               cfg_min_pts  = value[12:0];
        endcase
    endtask

    task automatic drain();
        while (pending.size() != 0 || point.valid || expected_groups.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYC) @(posedge clk);
    endtask

    task automatic configure(int md, int pr, int sn, int mp);
        drain();
        reg_write(sbg_pkg::REG_MAX_DIST, md);
        reg_write(sbg_pkg::REG_PROP, pr);
        reg_write(sbg_pkg::REG_SINE, sn);
        reg_write(sbg_pkg::REG_MIN_PTS, mp);
    endtask

    task automatic add_point(int x, int y, logic last);
        point_t p;
        p.x = 18'(x);
        p.y = 18'(y);
        p.last = last;
        pending = {pending, p};
    endtask

    function automatic int any_coord();
        return int'($urandom_range(0, 262142)) - 131071;
    endfunction

    // clustered scans with random walks, jumps and some noise
    task automatic add_scans(int n_items);
        int cx, cy, len, k, step;
        while (n_items > 0)
        begin
            len = ($urandom_range(0, 9) == 0) ? $urandom_range(1, 3) : $urandom_range(4, 40);
            cx = any_coord();
            cy = any_coord();
            if ($urandom_range(0, 2) != 0)
            begin
                cx = cx / 64;
                cy = cy / 64;
            end
            for (k = 0; k < len && n_items > 0; k++)
            begin
                case ($urandom_range(0, 9))
                    0:       begin cx = any_coord(); cy = any_coord(); end
                    1, 2:    begin cx = cx + $urandom_range(0, 2000) - 1000;
                                   cy = cy + $urandom_range(0, 2000) - 1000; end
                    default: begin step = $urandom_range(0, 120);
                                   cx = cx + $urandom_range(0, step) - step / 2;
                                   cy = cy + $urandom_range(0, step) - step / 2; end
                endcase
                if (cx > 131071) cx = 131071;
                if (cx < -131071) cx = -131071;
                if (cy > 131071) cy = 131071;
                if (cy < -131071) cy = -131071;
                n_items--;
                add_point(cx, cy, (k == len - 1) || n_items == 0 ||
                          $urandom_range(0, 99) == 0);
            end
        end
    endtask

    initial
    begin
        int i;
        point.valid = 1'b0;
        point.x_mm = '0;
        point.y_mm = '0;
        point.last_of_scan = 1'b0;
        group.ready = 1'b0;
        clear_scan();
        repeat (11) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        // directed: single-point scan, extremes, zero range, identical points,
        // collinear points, occlusion in both directions
        add_point(0, 0, 1'b1);
        add_point(131071, 131071, 1'b0);
        add_point(-131071, -131071, 1'b0);
        add_point(-131071, 131071, 1'b0);
        add_point(0, 0, 1'b0);
        add_point(0, 0, 1'b0);
        add_point(5000, 0, 1'b0);
        add_point(10000, 0, 1'b0);
        add_point(10050, 0, 1'b0);
        add_point(3000, 100, 1'b0);
        add_point(3010, 110, 1'b0);
        add_point(3020, 120, 1'b0);
        add_point(3030, 130, 1'b0);
        add_point(3040, 140, 1'b0);
        add_point(8000, 300, 1'b0);
        add_point(8010, 305, 1'b0);
        add_point(2000, 2000, 1'b0);
        add_point(131071, -131071, 1'b1);
        add_point(7, -7, 1'b1);
        add_scans(250);

        configure(0, 0, 0, 1);
        add_point(100, 100, 1'b0);
        add_point(100, 100, 1'b0);
        add_point(101, 100, 1'b1);
        add_scans(150);

        configure(65535, 65535, 65535, 4096);
        add_scans(150);

        // long single-group scan, no idling on either side
        configure(100, 412, 823, 150);
        quiet = 1'b1;
        for (i = 0; i < 200; i++)
            add_point(2000 + (i % 3), 1000, i == 199);
        drain();
        quiet = 1'b0;

        configure($urandom_range(0, 3000), $urandom_range(0, 4000),
                  $urandom_range(0, 65535), $urandom_range(1, 12));
        add_scans(380);
        drain();

        $display("%0d points sent, %0d groups checked, %0d breaks predicted",
                 n_points, n_groups, n_breaks);
        $display("register extremes, a long idle-free scan and random clustered scans covered");
        if (errors == 0)
            $display("== PASS ==");
        else
            $display("== FAIL ==");
        $finish;
    end
endmodule

// File: sim.f
src/sbg_pkg.sv
src/sbg_point_if.sv
src/sbg_group_if.sv
src/sbg_mul.sv
src/sbg_sqrt.sv
src/sbg_dpath.sv
src/sbg_ctrl.sv
src/scan_breakpoint_grouper.sv
verif/scan_breakpoint_grouper_test.sv
